// ===== hw/rtl/c_token_lexer_defines.svh =====
// ----------------------------------------------------------------------------
// c_token_lexer_defines.svh
// Assertion macros of the C token lexer RTL, used by ctl_rbuf.
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_LEXER_DEFINES_SVH
`define C_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CTL_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("c_token_lexer: assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define CTL_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("c_token_lexer: assertion failed");

`endif

// ===== hw/rtl/ctl_pkg.sv =====
// ----------------------------------------------------------------------------
// ctl_pkg
// Types, token codes, keyword table and character classes of the C lexer.
// ----------------------------------------------------------------------------
package ctl_pkg;

  localparam int CTL_MAX_LEXEME    = 1024;
  localparam int CTL_KEYWORD_CHARS = 16;
  localparam int CTL_RBUF_DEPTH    = 4;
  localparam int KW_COUNT          = 45;
  localparam int KW_MAX_LEN        = 14;
  localparam int LEN_MAX           = 1023;

  // token codes
  localparam logic [6:0] K_END        = 7'd0;
  localparam logic [6:0] K_IDENT      = 7'd46;
  localparam logic [6:0] K_ICONST     = 7'd47;
  localparam logic [6:0] K_FCONST     = 7'd48;
  localparam logic [6:0] K_STRING     = 7'd49;
  localparam logic [6:0] K_ELLIPSIS   = 7'd50;
  localparam logic [6:0] K_SHR_ASSIGN = 7'd51;
  localparam logic [6:0] K_SHL_ASSIGN = 7'd52;
  localparam logic [6:0] K_SHR        = 7'd61;
  localparam logic [6:0] K_SHL        = 7'd62;
  localparam logic [6:0] K_DOT        = 7'd82;

  // error codes
  localparam logic [2:0] E_NONE         = 3'd0;
  localparam logic [2:0] E_OPEN_COMMENT = 3'd1;
  localparam logic [2:0] E_OPEN_STRING  = 3'd2;
  localparam logic [2:0] E_OPEN_CHAR    = 3'd3;
  localparam logic [2:0] E_EMPTY_CHAR   = 3'd4;

  // characters with a role of their own
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  typedef struct packed {
    logic [6:0] token_kind;
    logic [9:0] lexeme_length;
    logic [2:0] error_code;
    logic       last_of_run;
  } ctl_res_t;

  // results of one accepted transaction, 0 to 2 of them
  typedef struct packed {
    logic [1:0] count;
    ctl_res_t   first;
    ctl_res_t   second;
  } ctl_push_t;

  // keyword text, right aligned: first character in the highest used byte
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
    "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
    {"_Static_", "assert"}, {"_Thread_", "local"}, "__func__"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    4, 5, 4, 4, 5, 8, 7, 2, 6, 4, 4, 6, 5, 3, 4, 2, 6, 3, 4, 8, 8, 6, 5,
    6, 6, 6, 6, 6, 7, 5, 8, 4, 8, 5, 8, 8, 7, 5, 8, 8, 10, 9, 14, 13, 8
  };

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_suffix(input logic [7:0] b);
    return b inside {"u", "U", "l", "L", "f", "F"};
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == "_");
  endfunction

  // single character tokens; 0 for an unknown character
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      8'h3B:   k = 7'd72;
      8'h7B:   k = 7'd73;
      8'h7D:   k = 7'd74;
      8'h2C:   k = 7'd75;
      8'h3A:   k = 7'd76;
      8'h3D:   k = 7'd77;
      8'h28:   k = 7'd78;
      8'h29:   k = 7'd79;
      8'h5B:   k = 7'd80;
      8'h5D:   k = 7'd81;
      8'h2E:   k = 7'd82;
      8'h26:   k = 7'd83;
      8'h21:   k = 7'd84;
      8'h7E:   k = 7'd85;
      8'h2D:   k = 7'd86;
      8'h2B:   k = 7'd87;
      8'h2A:   k = 7'd88;
      8'h2F:   k = 7'd89;
      8'h25:   k = 7'd90;
      8'h3C:   k = 7'd91;
      8'h3E:   k = 7'd92;
      8'h5E:   k = 7'd93;
      8'h7C:   k = 7'd94;
      8'h3F:   k = 7'd95;
      default: k = K_END;
    endcase
    return k;
  endfunction

  // two character operators; 0 when the pair is not one
  function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] k;
    case ({a, b})
      "+=":    k = 7'd53;
      "-=":    k = 7'd54;
      "*=":    k = 7'd55;
      "/=":    k = 7'd56;
      "%=":    k = 7'd57;
      "&=":    k = 7'd58;
      "^=":    k = 7'd59;
      "|=":    k = 7'd60;
      "++":    k = 7'd63;
      "--":    k = 7'd64;
      "->":    k = 7'd65;
      "&&":    k = 7'd66;
      "||":    k = 7'd67;
      "<=":    k = 7'd68;
      ">=":    k = 7'd69;
      "==":    k = 7'd70;
      "!=":    k = 7'd71;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/ctl_if.sv =====
// ----------------------------------------------------------------------------
// ctl_if
// Valid/ready channels of the C lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface ctl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_input;

  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface ctl_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] token_kind;
  logic [9:0] lexeme_length;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output token_kind, output lexeme_length,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input lexeme_length,
                  input error_code, input last_of_run, output ready);
endinterface

// ===== hw/rtl/ctl_scan.sv =====
// ----------------------------------------------------------------------------
// ctl_scan
// Scanner state machine: one byte per transaction, up to two tokens out.
// ----------------------------------------------------------------------------
module ctl_scan
  import ctl_pkg::*;
#(
  parameter int MAX_LEXEME    = CTL_MAX_LEXEME,
  parameter int KEYWORD_CHARS = CTL_KEYWORD_CHARS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] byte_value,
  input  logic      end_of_input,
  output ctl_push_t push
);

  localparam int CW = $clog2(MAX_LEXEME);
  localparam int IW = $clog2(KEYWORD_CHARS);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_ID       = 5'd1;
  localparam logic [4:0] ST_ID_PRE   = 5'd2;
  localparam logic [4:0] ST_ID_U8    = 5'd3;
  localparam logic [4:0] ST_DEC_INT  = 5'd4;
  localparam logic [4:0] ST_DEC_FRAC = 5'd5;
  localparam logic [4:0] ST_HEX_INT  = 5'd6;
  localparam logic [4:0] ST_HEX_FRAC = 5'd7;
  localparam logic [4:0] ST_EXP_SIGN = 5'd8;
  localparam logic [4:0] ST_EXP_DIG  = 5'd9;
  localparam logic [4:0] ST_SUFFIX   = 5'd10;
  localparam logic [4:0] ST_STR      = 5'd11;
  localparam logic [4:0] ST_STR_ESC  = 5'd12;
  localparam logic [4:0] ST_CHR      = 5'd13;
  localparam logic [4:0] ST_CHR_ESC  = 5'd14;
  localparam logic [4:0] ST_CMT      = 5'd15;
  localparam logic [4:0] ST_CMT_STAR = 5'd16;
  localparam logic [4:0] ST_LINE_CMT = 5'd17;
  localparam logic [4:0] ST_OP1      = 5'd18;
  localparam logic [4:0] ST_OP2      = 5'd19;

  typedef struct packed {
    logic       go;
    logic [4:0] st;
    logic       digit;
    logic       chr;
    logic       oper;
  } idle_t;

  logic [4:0]    state;
  logic [CW-1:0] count;
  logic          float_seen;
  logic          literal_has_content;
  logic [7:0]    pending_op;
  logic [7:0]    keyword_prefix [KEYWORD_CHARS];

  logic [4:0]    state_next;
  logic          float_seen_next;
  logic          literal_has_content_next;
  logic [7:0]    pending_op_next;
  logic          tk;
  logic [CW-1:0] tk_base;
  logic          cnt_clr;
  logic [1:0]    n;
  ctl_res_t      r [2];
  logic [6:0]    kw_kind;

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
    return (32'(c) < MAX_LEXEME - 1) ? c + 1'b1 : c;
  endfunction

  function automatic logic [9:0] len_out(input logic [CW-1:0] c);
    return (32'(c) > LEN_MAX) ? 10'(LEN_MAX) : 10'(c);
  endfunction

  function automatic ctl_res_t mk(input logic [6:0] k, input logic [9:0] len,
                                  input logic [2:0] err);
    ctl_res_t x;
    x.token_kind    = k;
    x.lexeme_length = len;
    x.error_code    = err;
    x.last_of_run   = 1'b0;
    return x;
  endfunction

  // how a byte opens a token from idle
  function automatic idle_t idle_dec(input logic [7:0] b);
    idle_t d;
    d.go    = !is_space(b);
    d.digit = 1'b0;
    d.chr   = 1'b0;
    d.oper  = 1'b0;
    if (is_alpha(b) || (b == "_")) begin
      d.st = (b == "L" || b == "u" || b == "U") ? ST_ID_PRE : ST_ID;
    end else if (is_digit(b)) begin
      d.st    = ST_DEC_INT;
      d.digit = 1'b1;
    end else if (b == CH_DQUOTE) begin
      d.st = ST_STR;
    end else if (b == CH_QUOTE) begin
      d.st  = ST_CHR;
      d.chr = 1'b1;
    end else begin
      d.st   = ST_OP1;
      d.oper = 1'b1;
    end
    return d;
  endfunction

  // keyword compare against the whole table in parallel
  always_comb begin
    logic hit;
    int   pos;
    kw_kind = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      hit = (32'(count) == KW_LEN[i]);
      for (int k = 0; k < KW_MAX_LEN; k++) begin
        pos = (k < KW_LEN[i]) ? 8 * (KW_LEN[i] - 1 - k) : 0;
        if (k < KW_LEN[i] && keyword_prefix[k] != KW_TEXT[i][pos +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kw_kind = 7'(i + 1);
      end
    end
    if (32'(count) > KEYWORD_CHARS) begin
      kw_kind = K_IDENT;
    end
  end

  // next state and results of one byte or end of input
  always_comb begin
    logic [7:0]    b;
    logic [7:0]    c;
    logic [CW-1:0] cp1;
    logic          rescan;
    logic          do_idle;
    logic          pre;
    logic [6:0]    pk;
    idle_t         id;
    b       = byte_value;
    c       = pending_op;
    cp1     = cnt_inc(count);
    rescan  = 1'b0;
    do_idle = 1'b0;
    pre     = (state != ST_ID);
    pk      = pair_kind(c, b);
    id      = idle_dec(b);
    state_next               = state;
    float_seen_next          = float_seen;
    literal_has_content_next = literal_has_content;
    pending_op_next          = pending_op;
    tk      = 1'b0;
    tk_base = count;
    cnt_clr = 1'b0;
    n       = 2'd0;
    r[0]    = '0;
    r[1]    = '0;

    if (end_of_input) begin
      // flush what is pending
      case (state)
        ST_ID, ST_ID_PRE, ST_ID_U8: begin
          r[n[0]] = mk(kw_kind, len_out(count), E_NONE); n = n + 2'd1;
        end
        ST_DEC_INT, ST_DEC_FRAC, ST_HEX_INT, ST_HEX_FRAC, ST_EXP_SIGN, ST_EXP_DIG,
        ST_SUFFIX: begin
          r[n[0]] = mk(float_seen ? K_FCONST : K_ICONST, len_out(count), E_NONE);
          n = n + 2'd1;
        end
        ST_STR, ST_STR_ESC: begin
          r[n[0]] = mk(K_END, len_out(count), E_OPEN_STRING); n = n + 2'd1;
        end
        ST_CHR, ST_CHR_ESC: begin
          r[n[0]] = mk(K_END, len_out(count), E_OPEN_CHAR); n = n + 2'd1;
        end
        ST_CMT, ST_CMT_STAR: begin
          r[n[0]] = mk(K_END, len_out(count), E_OPEN_COMMENT); n = n + 2'd1;
        end
        ST_OP1: begin
          r[n[0]] = mk(single_kind(c), 10'd1, E_NONE); n = n + 2'd1;
        end
        ST_OP2: begin
          if (c == CH_DOT) begin
            r[n[0]] = mk(K_DOT, 10'd1, E_NONE); n = n + 2'd1;
            r[n[0]] = mk(K_DOT, 10'd1, E_NONE); n = n + 2'd1;
          end else begin
            r[n[0]] = mk((c == CH_GT) ? K_SHR : K_SHL, 10'd2, E_NONE); n = n + 2'd1;
          end
        end
        default: begin
        end
      endcase
      if (n == 2'd0) begin
        r[0] = mk(K_END, 10'd0, E_NONE); n = 2'd1;
      end
      state_next = ST_IDLE;
      cnt_clr    = 1'b1;
    end else begin
      case (state)
        ST_IDLE: do_idle = 1'b1;
        ST_ID, ST_ID_PRE, ST_ID_U8: begin
          if (pre && b == CH_DQUOTE) begin
            tk = 1'b1; state_next = ST_STR;
          end else if (pre && b == CH_QUOTE) begin
            literal_has_content_next = 1'b0; tk = 1'b1; state_next = ST_CHR;
          end else if (state == ST_ID_PRE && b == "8" && keyword_prefix[0] == "u") begin
            tk = 1'b1; state_next = ST_ID_U8;
          end else if (is_word(b)) begin
            tk = 1'b1; state_next = ST_ID;
          end else begin
            r[n[0]] = mk(kw_kind, len_out(count), E_NONE); n = n + 2'd1;
            state_next = ST_IDLE; rescan = 1'b1;
          end
        end
        ST_DEC_INT: begin
          if (32'(count) == 1 && keyword_prefix[0] == "0" && (b == "x" || b == "X")) begin
            tk = 1'b1; state_next = ST_HEX_INT;
          end else if (is_digit(b)) begin
            tk = 1'b1;
          end else if (b == CH_DOT) begin
            float_seen_next = 1'b1; tk = 1'b1; state_next = ST_DEC_FRAC;
          end else if (b == "e" || b == "E") begin
            float_seen_next = 1'b1; tk = 1'b1; state_next = ST_EXP_SIGN;
          end else if (is_suffix(b)) begin
            tk = 1'b1; state_next = ST_SUFFIX;
          end else begin
            rescan = 1'b1;
          end
        end
        ST_DEC_FRAC: begin
          if (is_digit(b)) begin
            tk = 1'b1;
          end else if (b == "e" || b == "E") begin
            tk = 1'b1; state_next = ST_EXP_SIGN;
          end else if (is_suffix(b)) begin
            tk = 1'b1; state_next = ST_SUFFIX;
          end else begin
            rescan = 1'b1;
          end
        end
        ST_HEX_INT, ST_HEX_FRAC: begin
          if (is_xdigit(b)) begin
            tk = 1'b1;
          end else if (b == CH_DOT && state == ST_HEX_INT) begin
            float_seen_next = 1'b1; tk = 1'b1; state_next = ST_HEX_FRAC;
          end else if (b == "p" || b == "P") begin
            float_seen_next = 1'b1; tk = 1'b1; state_next = ST_EXP_SIGN;
          end else if (is_suffix(b)) begin
            tk = 1'b1; state_next = ST_SUFFIX;
          end else begin
            rescan = 1'b1;
          end
        end
        ST_EXP_SIGN: begin
          if (b == CH_PLUS || b == CH_MINUS || is_digit(b)) begin
            tk = 1'b1; state_next = ST_EXP_DIG;
          end else if (is_suffix(b)) begin
            tk = 1'b1; state_next = ST_SUFFIX;
          end else begin
            rescan = 1'b1;
          end
        end
        ST_EXP_DIG: begin
          if (is_digit(b)) begin
            tk = 1'b1;
          end else if (is_suffix(b)) begin
            tk = 1'b1; state_next = ST_SUFFIX;
          end else begin
            rescan = 1'b1;
          end
        end
        ST_SUFFIX: begin
          if (is_suffix(b)) begin
            tk = 1'b1;
          end else begin
            rescan = 1'b1;
          end
        end
        ST_STR: begin
          if (b == CH_DQUOTE) begin
            tk = 1'b1;
            r[n[0]] = mk(K_STRING, len_out(cp1), E_NONE); n = n + 2'd1;
            state_next = ST_IDLE;
          end else if (b == CH_LF) begin
            r[n[0]] = mk(K_END, len_out(count), E_OPEN_STRING); n = n + 2'd1;
            state_next = ST_IDLE;
          end else begin
            tk = 1'b1;
            if (b == CH_BSLASH) state_next = ST_STR_ESC;
          end
        end
        ST_STR_ESC: begin
          tk = 1'b1; state_next = ST_STR;
        end
        ST_CHR: begin
          if (b == CH_QUOTE) begin
            tk = 1'b1;
            if (literal_has_content) begin
              r[n[0]] = mk(K_ICONST, len_out(cp1), E_NONE);
            end else begin
              r[n[0]] = mk(K_END, len_out(cp1), E_EMPTY_CHAR);
            end
            n = n + 2'd1;
            state_next = ST_IDLE;
          end else if (b == CH_LF) begin
            r[n[0]] = mk(K_END, len_out(count), E_OPEN_CHAR); n = n + 2'd1;
            state_next = ST_IDLE;
          end else begin
            tk = 1'b1;
            literal_has_content_next = 1'b1;
            if (b == CH_BSLASH) state_next = ST_CHR_ESC;
          end
        end
        ST_CHR_ESC: begin
          tk = 1'b1; state_next = ST_CHR;
        end
        ST_CMT: begin
          if (b == CH_STAR) state_next = ST_CMT_STAR;
        end
        ST_CMT_STAR: begin
          if (b == CH_SLASH) state_next = ST_IDLE;
          else if (b != CH_STAR) state_next = ST_CMT;
        end
        ST_LINE_CMT: begin
          if (b == CH_LF) state_next = ST_IDLE;
        end
        ST_OP1: begin
          if (c == CH_SLASH && b == CH_STAR) begin
            state_next = ST_CMT;
          end else if (c == CH_SLASH && b == CH_SLASH) begin
            state_next = ST_LINE_CMT;
          end else if (c == b && (c == CH_DOT || c == CH_GT || c == CH_LT)) begin
            tk = 1'b1; state_next = ST_OP2;
          end else if (pk != K_END) begin
            r[n[0]] = mk(pk, 10'd2, E_NONE); n = n + 2'd1;
            state_next = ST_IDLE;
          end else begin
            r[n[0]] = mk(single_kind(c), 10'd1, E_NONE); n = n + 2'd1;
            state_next = ST_IDLE; rescan = 1'b1;
          end
        end
        ST_OP2: begin
          state_next = ST_IDLE;
          if (c == CH_DOT) begin
            if (b == CH_DOT) begin
              r[n[0]] = mk(K_ELLIPSIS, 10'd3, E_NONE); n = n + 2'd1;
            end else begin
              r[n[0]] = mk(K_DOT, 10'd1, E_NONE); n = n + 2'd1;
              r[n[0]] = mk(K_DOT, 10'd1, E_NONE); n = n + 2'd1;
              rescan = 1'b1;
            end
          end else if (b == CH_EQ) begin
            r[n[0]] = mk((c == CH_GT) ? K_SHR_ASSIGN : K_SHL_ASSIGN, 10'd3, E_NONE);
            n = n + 2'd1;
          end else begin
            r[n[0]] = mk((c == CH_GT) ? K_SHR : K_SHL, 10'd2, E_NONE); n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // a number ends on a byte that does not extend it
      if (rescan && state >= ST_DEC_INT && state <= ST_SUFFIX) begin
        r[n[0]] = mk(float_seen ? K_FCONST : K_ICONST, len_out(count), E_NONE);
        n = n + 2'd1;
        state_next = ST_IDLE;
      end

      // idle handling, also for a byte that closed the previous token
      if (do_idle || rescan) begin
        state_next = ST_IDLE;
        if (id.go) begin
          tk         = 1'b1;
          tk_base    = '0;
          state_next = id.st;
          if (id.digit) float_seen_next = 1'b0;
          if (id.chr)   literal_has_content_next = 1'b0;
          if (id.oper)  pending_op_next = b;
        end
      end
    end

    // flag the last result of this transaction
    if (n == 2'd1) r[0].last_of_run = 1'b1;
    if (n == 2'd2) r[1].last_of_run = 1'b1;
  end

  assign push.count  = accept ? n : 2'd0;
  assign push.first  = r[0];
  assign push.second = r[1];

  // scanner control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      count               <= '0;
      float_seen          <= 1'b0;
      literal_has_content <= 1'b0;
      pending_op          <= '0;
    end else if (accept) begin
      state               <= state_next;
      float_seen          <= float_seen_next;
      literal_has_content <= literal_has_content_next;
      pending_op          <= pending_op_next;
      if (cnt_clr) count <= '0;
      else if (tk) count <= cnt_inc(tk_base);
    end
  end

  // leading characters of the lexeme, for the keyword compare
  always_ff @(posedge clk) begin
    if (accept && tk && 32'(tk_base) < KEYWORD_CHARS) begin
      keyword_prefix[IW'(tk_base)] <= byte_value;
    end
  end

endmodule

// ===== hw/rtl/ctl_rbuf.sv =====
// ----------------------------------------------------------------------------
// ctl_rbuf
// Token result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`include "c_token_lexer_defines.svh"

module ctl_rbuf
  import ctl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ctl_push_t push,
  output logic      space_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output ctl_res_t  out_rec
);

  localparam int PW = $clog2(CTL_RBUF_DEPTH);
  localparam int FW = $clog2(CTL_RBUF_DEPTH + 1);

  ctl_res_t        slots [CTL_RBUF_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [FW-1:0]   fill;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != '0);
  assign out_rec   = slots[rptr];
  // room for the worst case of one transaction
  assign space_ok  = (32'(fill) <= CTL_RBUF_DEPTH - 2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + PW'(push.count);
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + FW'(push.count) - FW'(pop);
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots[wptr] <= push.first;
    if (push.count == 2'd2) slots[wptr + 1'b1] <= push.second;
  end

  `CTL_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill) <= CTL_RBUF_DEPTH)
  `CTL_ASSERT_NOW(a_one_last, push.count == 2'd1, push.first.last_of_run)
  `CTL_ASSERT_NOW(a_two_last, push.count == 2'd2,
                  !push.first.last_of_run && push.second.last_of_run)
  `CTL_ASSERT_NEXT(a_fill_drop, pop && push.count == 2'd0, fill == $past(fill) - 1'b1)

endmodule

// ===== hw/rtl/c_token_lexer.sv =====
// ----------------------------------------------------------------------------
// c_token_lexer
// Streaming C11 lexer: source bytes in, classified tokens out.
// ----------------------------------------------------------------------------
// Use: byte_in carries one source byte per transaction, or an end-of-input
// mark that flushes the token in progress and returns the scanner to idle.
// token_out carries one token per transaction: kind, lexeme length, error
// code and a flag on the last token caused by the same input byte.
// Throughput: one byte per cycle while each byte yields at most one token
// and token_out is ready; a byte may yield two tokens, and then the output
// side sets the pace at one token per cycle. The scanner state machine takes
// a byte in the cycle it is accepted; its tokens are registered in the queue.
// A four-entry result queue parts the two sides: byte_in.ready stays high
// while the queue has room for two tokens, so a stalled receiver backs up
// into the byte channel only once the queue holds three or more.
// Reset (synchronous, active high) empties the queue and puts the scanner
// in idle between tokens.
// ----------------------------------------------------------------------------
module c_token_lexer
  import ctl_pkg::*;
#(
  parameter int MAX_LEXEME    = CTL_MAX_LEXEME,
  parameter int KEYWORD_CHARS = CTL_KEYWORD_CHARS
) (
  input  logic      clk,
  input  logic      rst,
  ctl_in_if.sink    byte_in,
  ctl_out_if.source token_out
);

  logic      accept;
  logic      space_ok;
  ctl_push_t push;
  ctl_res_t  out_rec;

  assign byte_in.ready = space_ok;
  assign accept        = byte_in.valid && space_ok;

  ctl_scan #(
    .MAX_LEXEME    (MAX_LEXEME),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .byte_value   (byte_in.byte_value),
    .end_of_input (byte_in.end_of_input),
    .push         (push)
  );

  ctl_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_rec   (out_rec)
  );

  assign token_out.token_kind    = out_rec.token_kind;
  assign token_out.lexeme_length = out_rec.lexeme_length;
  assign token_out.error_code    = out_rec.error_code;
  assign token_out.last_of_run   = out_rec.last_of_run;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for c_token_lexer. Source bytes go in over byte_in.
// A scanner model in the bench predicts the tokens of each accepted
// transaction. Every token on token_out is compared with the oldest
// prediction. Directed C fragments, random well-formed source with noise,
// output back-pressure and a full drain are each run as a test task.
// ----------------------------------------------------------------------------
module testbench;
  import ctl_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctl_in_if  byte_in ();
  ctl_out_if token_out ();

  c_token_lexer u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .token_out (token_out)
  );

  always #6 clk = ~clk;

  // scanner states of the bench model
  typedef enum int {
    S_IDLE, S_ID, S_ID_PRE, S_ID_U8, S_DEC_INT, S_DEC_FRAC, S_HEX_INT, S_HEX_FRAC,
    S_EXP_SIGN, S_EXP_DIG, S_SUFFIX, S_STR, S_STR_ESC, S_CHR, S_CHR_ESC,
    S_CMT, S_CMT_STAR, S_LINE_CMT, S_OP1, S_OP2
  } scan_st_t;

  localparam logic [6:0] K_OR_CONST = 7'd47;
  localparam string SINGLES = ";{},:=()[].&!~-+*/%<>^|?";

  string kw_names [45] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
    "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
    {"_Static_", "assert"}, {"_Thread_", "local"}, "__func__"
  };

  // model state
  scan_st_t   st;
  logic [7:0] head_chars [16];
  int         lex_cnt;
  bit         frac_seen;
  bit         chr_content;
  logic [7:0] op_char;
  int         run_n;

  ctl_res_t tokens_due [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  bit  rx_calm = 0;
  bit  tx_calm = 0;

  // --------------------------------------------------------------------------
  // token model
  // --------------------------------------------------------------------------
  function automatic bit dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit xdig(logic [7:0] b);
    return dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction
  function automatic bit sfx(logic [7:0] b);
    return b == "u" || b == "U" || b == "l" || b == "L" || b == "f" || b == "F";
  endfunction

  function automatic void take_char(logic [7:0] b);
    if (lex_cnt < 16) head_chars[lex_cnt] = b;
    if (lex_cnt < 1023) lex_cnt++;
  endfunction

  function automatic void put_token(logic [6:0] k, int len, logic [2:0] err);
    ctl_res_t r;
    if (run_n < 2) begin
      r.token_kind = k;
      r.lexeme_length = (len > 1023) ? 10'd1023 : len[9:0];
      r.error_code = err;
      r.last_of_run = 1'b0;
      tokens_due.push_back(r);
      run_n++;
    end
    st = S_IDLE;
  endfunction

  function automatic logic [6:0] word_kind();
    string w;
    w = "";
    if (lex_cnt > 16) return K_IDENT;
    for (int i = 0; i < lex_cnt; i++) w = {w, string'(head_chars[i])};
    foreach (kw_names[i]) if (kw_names[i] == w) return 7'(i + 1);
    return K_IDENT;
  endfunction

  function automatic logic [6:0] one_char_kind(logic [7:0] c);
    for (int i = 0; i < 24; i++) if (SINGLES[i] == c) return 7'(72 + i);
    return K_END;
  endfunction

  function automatic logic [6:0] two_char_kind(logic [7:0] a, logic [7:0] b);
    case ({a, b})
      "+=": return 7'd53;  "-=": return 7'd54;  "*=": return 7'd55;
      "/=": return 7'd56;  "%=": return 7'd57;  "&=": return 7'd58;
      "^=": return 7'd59;  "|=": return 7'd60;  "++": return 7'd63;
      "--": return 7'd64;  "->": return 7'd65;  "&&": return 7'd66;
      "||": return 7'd67;  "<=": return 7'd68;  ">=": return 7'd69;
      "==": return 7'd70;  "!=": return 7'd71;
      default: return K_END;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] b);
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
    lex_cnt = 0;
    take_char(b);
    if (alpha(b) || b == "_") st = (b == "L" || b == "u" || b == "U") ? S_ID_PRE : S_ID;
    else if (dig(b)) begin frac_seen = 0; st = S_DEC_INT; end
    else if (b == CH_DQUOTE) st = S_STR;
    else if (b == CH_QUOTE) begin chr_content = 0; st = S_CHR; end
    else begin op_char = b; st = S_OP1; end
  endfunction

  function automatic void move(logic [7:0] b, scan_st_t s);
    take_char(b);
    st = s;
  endfunction

  // one byte in the current state; returns 1 when it must be scanned again from idle
  function automatic bit scan_byte(logic [7:0] b);
    logic [6:0] pk;
    case (st)
      S_IDLE: start_token(b);
      S_ID_PRE, S_ID_U8: begin
        if (b == CH_DQUOTE) move(b, S_STR);
        else if (b == CH_QUOTE) begin chr_content = 0; move(b, S_CHR); end
        else if (st == S_ID_PRE && b == "8" && head_chars[0] == "u") move(b, S_ID_U8);
        else if (alpha(b) || dig(b) || b == "_") move(b, S_ID);
        else begin put_token(word_kind(), lex_cnt, E_NONE); return 1; end
      end
      S_ID: begin
        if (alpha(b) || dig(b) || b == "_") take_char(b);
        else begin put_token(word_kind(), lex_cnt, E_NONE); return 1; end
      end
      S_DEC_INT: begin
        if (lex_cnt == 1 && head_chars[0] == "0" && (b == "x" || b == "X")) move(b, S_HEX_INT);
        else if (dig(b)) take_char(b);
        else if (b == CH_DOT) begin frac_seen = 1; move(b, S_DEC_FRAC); end
        else if (b == "e" || b == "E") begin frac_seen = 1; move(b, S_EXP_SIGN); end
        else if (sfx(b)) move(b, S_SUFFIX);
        else begin put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE); return 1; end
      end
      S_DEC_FRAC: begin
        if (dig(b)) take_char(b);
        else if (b == "e" || b == "E") move(b, S_EXP_SIGN);
        else if (sfx(b)) move(b, S_SUFFIX);
        else begin put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE); return 1; end
      end
      S_HEX_INT, S_HEX_FRAC: begin
        if (xdig(b)) take_char(b);
        else if (b == CH_DOT && st == S_HEX_INT) begin frac_seen = 1; move(b, S_HEX_FRAC); end
        else if (b == "p" || b == "P") begin frac_seen = 1; move(b, S_EXP_SIGN); end
        else if (sfx(b)) move(b, S_SUFFIX);
        else begin put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE); return 1; end
      end
      S_EXP_SIGN: begin
        if (b == CH_PLUS || b == CH_MINUS || dig(b)) move(b, S_EXP_DIG);
        else if (sfx(b)) move(b, S_SUFFIX);
        else begin put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE); return 1; end
      end
      S_EXP_DIG: begin
        if (dig(b)) take_char(b);
        else if (sfx(b)) move(b, S_SUFFIX);
        else begin put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE); return 1; end
      end
      S_SUFFIX: begin
        if (sfx(b)) take_char(b);
        else begin put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE); return 1; end
      end
      S_STR: begin
        if (b == CH_DQUOTE) begin take_char(b); put_token(K_STRING, lex_cnt, E_NONE); end
        else if (b == CH_LF) put_token(K_END, lex_cnt, E_OPEN_STRING);
        else begin take_char(b); if (b == CH_BSLASH) st = S_STR_ESC; end
      end
      S_STR_ESC: move(b, S_STR);
      S_CHR: begin
        if (b == CH_QUOTE) begin
          take_char(b);
          if (chr_content) put_token(K_OR_CONST, lex_cnt, E_NONE);
          else put_token(K_END, lex_cnt, E_EMPTY_CHAR);
        end else if (b == CH_LF) put_token(K_END, lex_cnt, E_OPEN_CHAR);
        else begin
          take_char(b);
          chr_content = 1;
          if (b == CH_BSLASH) st = S_CHR_ESC;
        end
      end
      S_CHR_ESC: move(b, S_CHR);
      S_CMT: if (b == CH_STAR) st = S_CMT_STAR;
      S_CMT_STAR: begin
        if (b == CH_SLASH) st = S_IDLE;
        else if (b != CH_STAR) st = S_CMT;
      end
      S_LINE_CMT: if (b == CH_LF) st = S_IDLE;
      S_OP1: begin
        pk = two_char_kind(op_char, b);
        if (op_char == CH_SLASH && b == CH_STAR) st = S_CMT;
        else if (op_char == CH_SLASH && b == CH_SLASH) st = S_LINE_CMT;
        else if (op_char == b && (b == CH_DOT || b == CH_GT || b == CH_LT)) move(b, S_OP2);
        else if (pk != K_END) put_token(pk, 2, E_NONE);
        else begin put_token(one_char_kind(op_char), 1, E_NONE); return 1; end
      end
      S_OP2: begin
        if (op_char == CH_DOT) begin
          if (b == CH_DOT) put_token(K_ELLIPSIS, 3, E_NONE);
          else begin
            put_token(K_DOT, 1, E_NONE);
            put_token(K_DOT, 1, E_NONE);
            return 1;
          end
        end else if (b == CH_EQ) put_token(op_char == CH_GT ? K_SHR_ASSIGN : K_SHL_ASSIGN, 3, E_NONE);
        else begin put_token(op_char == CH_GT ? K_SHR : K_SHL, 2, E_NONE); return 1; end
      end
      default: begin st = S_IDLE; start_token(b); end
    endcase
    return 0;
  endfunction

  // end of source: flush whatever is open
  function automatic void flush_source();
    case (st)
      S_ID, S_ID_PRE, S_ID_U8: put_token(word_kind(), lex_cnt, E_NONE);
      S_DEC_INT, S_DEC_FRAC, S_HEX_INT, S_HEX_FRAC, S_EXP_SIGN, S_EXP_DIG, S_SUFFIX:
        put_token(frac_seen ? K_FCONST : K_ICONST, lex_cnt, E_NONE);
      S_STR, S_STR_ESC: put_token(K_END, lex_cnt, E_OPEN_STRING);
      S_CHR, S_CHR_ESC: put_token(K_END, lex_cnt, E_OPEN_CHAR);
      S_CMT, S_CMT_STAR: put_token(K_END, lex_cnt, E_OPEN_COMMENT);
      S_OP1: put_token(one_char_kind(op_char), 1, E_NONE);
      S_OP2: begin
        if (op_char == CH_DOT) begin
          put_token(K_DOT, 1, E_NONE);
          put_token(K_DOT, 1, E_NONE);
        end else put_token(op_char == CH_GT ? K_SHR : K_SHL, 2, E_NONE);
      end
      default: ;
    endcase
    if (run_n == 0) put_token(K_END, 0, E_NONE);
    st = S_IDLE;
    lex_cnt = 0;
  endfunction

  function automatic void lex_predict(logic [7:0] b, bit eoi);
    run_n = 0;
    if (eoi) flush_source();
    else if (scan_byte(b)) void'(scan_byte(b));
    if (run_n > 0) tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // byte sender
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit eoi = 0);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.byte_value <= eoi ? 8'($urandom) : b;
    byte_in.end_of_input <= eoi;
    do @(posedge clk); while (!byte_in.ready);
    lex_predict(byte_in.byte_value, byte_in.end_of_input);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic lower_valid();
    byte_in.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (tokens_due.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // token receiver and checker
  // --------------------------------------------------------------------------
  int rx_stall = 0;

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      token_out.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stall > 0) begin
      token_out.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else token_out.ready <= 1'b1;
  end

  always @(posedge clk) begin
    ctl_res_t want;
    if (!rst && token_out.valid && token_out.ready) begin
      rx_stall <= rx_calm ? 0 : $urandom_range(0, 15);
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token: kind %0d len %0d err %0d",
                                       token_out.token_kind, token_out.lexeme_length,
                                       token_out.error_code);
      end else begin
        want = tokens_due.pop_front();
        if (token_out.token_kind !== want.token_kind ||
            token_out.lexeme_length !== want.lexeme_length ||
            token_out.error_code !== want.error_code ||
            token_out.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token mismatch: expected kind %0d len %0d err %0d last %0d,",
                      " got %0d %0d %0d %0d"},
                     want.token_kind, want.lexeme_length, want.error_code, want.last_of_run,
                     token_out.token_kind, token_out.lexeme_length, token_out.error_code,
                     token_out.last_of_run);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((byte_in.valid && byte_in.ready) || (token_out.valid && token_out.ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= 4000) begin
      $display("testbench failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_text("_Static_");
    send_text("assert __func__ u8\"a\\\"\" '' 'x' 0x1Fp+2L 1.e-3f ...");
    send_text("..x>>=<<a/*c**/ //z\n\"s\n'c\n");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(".");
    send_byte(".");
    send_byte(0, 1);
    send_byte(0, 1);
    send_text("/*");
    send_byte(0, 1);
  endtask

  // one fragment of plausible C, or noise
  task automatic send_fragment();
    string s;
    int pick, len;
    s = "";
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2: s = kw_names[$urandom_range(0, 44)];
      3, 4: begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) s = {s, string'(8'($urandom_range("a", "z")))};
      end
      5: s = {"0x", $sformatf("%0h", $urandom), ($urandom_range(0, 1) ? ".8p-1" : "uL")};
      6: s = $sformatf("%0d.%0de%0s%0d%0s", $urandom_range(0, 999), $urandom_range(0, 99),
                       $urandom_range(0, 1) ? "+" : "-", $urandom_range(0, 40),
                       $urandom_range(0, 1) ? "f" : "");
      7: s = $sformatf("%0d%0s", $urandom_range(0, 99999), $urandom_range(0, 1) ? "ull" : "");
      8: s = {$urandom_range(0, 1) ? "L\"" : "\"", "ab\\\"c", "\""};
      9: s = {$urandom_range(0, 1) ? "u'" : "'", $urandom_range(0, 1) ? "\\n" : "", "'"};
      10, 11: begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) s = {s, string'(SINGLES[$urandom_range(0, 23)])};
      end
      12: s = "/* x * y **/";
      13: s = "// line\n";
      14: s = $urandom_range(0, 1) ? "..." : "..";
      15: s = ">>=<<=";
      16, 17: begin
        send_byte(8'($urandom));
        return;
      end
      18: begin
        send_byte(0, 1);
        return;
      end
      default: s = "\n\t ";
    endcase
    send_text(s);
    if ($urandom_range(0, 2) != 0) send_byte(" ");
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ((i % 60) == 0) begin
        tx_calm = ($urandom_range(0, 2) == 0);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      send_fragment();
    end
    tx_calm = 0;
    rx_calm = 0;
  endtask

  // identifier longer than the keyword prefix
  task automatic test_long_lexeme();
    tx_calm = 1;
    rx_calm = 1;
    for (int i = 0; i < 40; i++) send_byte("q");
    send_byte(";");
    send_byte(0, 1);
    tx_calm = 0;
    rx_calm = 0;
  endtask

  // receiver held off while bytes keep coming
  task automatic test_backpressure();
    rx_hold = 300;
    tx_calm = 1;
    for (int i = 0; i < 30; i++) send_text("+;");
    tx_calm = 0;
  endtask

  task automatic test_drain();
    lower_valid();
    wait_drained();
    send_text("a=b;");
    send_byte(0, 1);
  endtask

  initial begin
    byte_in.valid = 1'b0;
    byte_in.byte_value = 8'h00;
    byte_in.end_of_input = 1'b0;
    token_out.ready = 1'b0;
    st = S_IDLE;
    lex_cnt = 0;
    frac_seen = 0;
    chr_content = 0;
    op_char = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_drain();
    test_random(20);
    test_long_lexeme();
    test_random(18);
    send_byte(0, 1);
    lower_valid();
    wait_drained();
    repeat (20) @(negedge clk);

    if (mismatches == 0 && tokens_due.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
